[rtl/ffwd_pkg.sv]
`default_nettype none

package ffwd_pkg;

  // Item kinds
  localparam logic [1:0] KIND_FEEDBACK = 2'd0;
  localparam logic [1:0] KIND_PLOT     = 2'd1;
  localparam logic [1:0] KIND_SWAP     = 2'd2;
  localparam logic [1:0] KIND_READ     = 2'd3;

  localparam int PIXEL_W = 16;
  localparam int POS_W   = 11;
  localparam int SCALE_W = 14;

  // RGB565 fade steps
  localparam logic [15:0] FADE_MASK_R = 16'hF800;
  localparam logic [15:0] FADE_STEP_R = 16'h0800;
  localparam logic [15:0] FADE_MASK_G = 16'h07E0;
  localparam logic [15:0] FADE_STEP_G = 16'h0020;
  localparam logic [15:0] FADE_MASK_B = 16'h001F;
  localparam logic [15:0] FADE_STEP_B = 16'h0001;

  // Classified item as it travels from front to back
  typedef struct packed {
    logic [1:0]               kind;
    logic                     outside;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [PIXEL_W-1:0]       colour;
  } cmd_t;

  // Blue to zero, green and red floor at one step; fields never borrow from each other
  function automatic logic [15:0] fade(input logic [15:0] c);
    logic [15:0] v;
    v = c;
    if (v != 16'd0) begin
      if ((v & FADE_MASK_B) != 16'd0) v = v - FADE_STEP_B;
      if ((v & FADE_MASK_G) > FADE_STEP_G) v = v - FADE_STEP_G;
      if ((v & FADE_MASK_R) > FADE_STEP_R) v = v - FADE_STEP_R;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/ffwd_ram.sv]
`default_nettype none

module ffwd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/ffwd_fifo.sv]
`default_nettype none

module ffwd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [PW:0]      cnt;

  assign full    = (cnt == (PW+1)'(DEPTH));
  assign empty   = (cnt == '0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == PW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == PW'(DEPTH-1)) ? '0 : rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

[rtl/ffwd_front.sv]
`default_nettype none

module ffwd_front
  import ffwd_pkg::*;
#(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 240
) (
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               kind,
  input  wire logic signed [POS_W-1:0]  pos_x,
  input  wire logic signed [POS_W-1:0]  pos_y,
  input  wire logic [PIXEL_W-1:0]       colour,
  input  wire logic                     q_full,
  input  wire logic                     busy,
  output logic                          push,
  output cmd_t                          cmd,
  output logic [$clog2(FRAME_WIDTH*FRAME_HEIGHT)-1:0] here
);

  localparam int AW = $clog2(FRAME_WIDTH*FRAME_HEIGHT);
  localparam int XW = $clog2(FRAME_WIDTH);
  localparam int YW = $clog2(FRAME_HEIGHT);
  // one bit wider than a position so a 1024 limit still fits
  localparam logic [POS_W:0]   W_LIM = (POS_W+1)'(FRAME_WIDTH);
  localparam logic [POS_W:0]   H_LIM = (POS_W+1)'(FRAME_HEIGHT);
  localparam logic [AW-1:0]    W_A   = AW'(FRAME_WIDTH);

  logic in_frame;

  assign in_frame = !pos_x[POS_W-1] && ({1'b0, pos_x} < W_LIM) &&
                    !pos_y[POS_W-1] && ({1'b0, pos_y} < H_LIM);

  // Row-major address; only meaningful when inside
  assign here = AW'(pos_y[YW-1:0]) * W_A + AW'(pos_x[XW-1:0]);

  assign cmd.kind    = kind;
  assign cmd.outside = !in_frame;
  assign cmd.pos_x   = pos_x;
  assign cmd.pos_y   = pos_y;
  assign cmd.colour  = colour;

  assign in_stall = q_full | busy;
  assign push     = in_valid & !in_stall;

endmodule

`default_nettype wire

[rtl/ffwd_back.sv]
`default_nettype none

module ffwd_back
  import ffwd_pkg::*;
#(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 240
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic signed [SCALE_W-1:0]  scale_cos,
  input  wire logic signed [SCALE_W-1:0]  scale_sin,
  input  wire logic                       q_empty,
  input  wire cmd_t                       q_cmd,
  input  wire logic [$clog2(FRAME_WIDTH*FRAME_HEIGHT)-1:0] q_here,
  output logic                            q_pop,
  output logic                            busy,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [PIXEL_W-1:0]              pixel,
  output logic                            outside
);

  localparam int PIX = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW  = $clog2(PIX);
  localparam int XW  = $clog2(FRAME_WIDTH);
  localparam int YW  = $clog2(FRAME_HEIGHT);
  localparam int CX  = FRAME_WIDTH / 2;
  localparam int CY  = FRAME_HEIGHT / 2;
  localparam logic [AW-1:0] W_A = AW'(FRAME_WIDTH);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_DISP  = 4'd2;
  localparam logic [3:0] ST_MAP   = 4'd3;
  localparam logic [3:0] ST_ADDR  = 4'd4;
  localparam logic [3:0] ST_READ  = 4'd5;
  localparam logic [3:0] ST_DATA  = 4'd6;
  localparam logic [3:0] ST_RESP  = 4'd7;

  logic [3:0]    state;
  logic [AW-1:0] clr_cnt;
  logic          sel;
  cmd_t          w_cmd;
  logic [AW-1:0] w_here;

  logic signed [25:0] p_xc, p_ys, p_xs, p_yc;
  logic [XW-1:0] sx;
  logic [YW-1:0] sy;
  logic [AW-1:0] src;
  logic [PIXEL_W-1:0] pix;
  logic          outs;

  // mapping datapath
  logic signed [11:0] dx, dy;
  logic signed [26:0] rx, ry;
  logic signed [15:0] sxf, syf;
  logic [XW-1:0] sx_next;
  logic [YW-1:0] sy_next;

  // memory ports
  logic [PIXEL_W-1:0] rd0, rd1, cur_data, prev_data, faded, wr_data;
  logic [AW-1:0] wr_addr, rd_addr;
  logic wr_plot, wr_fb, wr_any, wr_en0, wr_en1, rd_en, clearing, res_free;

  assign dx = 12'(w_cmd.pos_x) - 12'(CX);
  assign dy = 12'(w_cmd.pos_y) - 12'(CY);

  assign rx = 27'(p_xc) - 27'(p_ys);
  assign ry = 27'(p_xs) + 27'(p_yc);

  // arithmetic right shift by 12 is the floor
  assign sxf = 16'($signed(rx[26:12])) + 16'(CX);
  assign syf = 16'($signed(ry[26:12])) + 16'(CY);

  always_comb begin
    if (sxf[15])                            sx_next = '0;
    else if (sxf[14:0] > 15'(FRAME_WIDTH-1)) sx_next = XW'(FRAME_WIDTH-1);
    else                                    sx_next = sxf[XW-1:0];
    if (syf[15])                             sy_next = '0;
    else if (syf[14:0] > 15'(FRAME_HEIGHT-1)) sy_next = YW'(FRAME_HEIGHT-1);
    else                                     sy_next = syf[YW-1:0];
  end

  // sel picks the previous frame; the current frame is the other RAM
  assign clearing  = (state == ST_CLEAR);
  assign cur_data  = sel ? rd0 : rd1;
  assign prev_data = sel ? rd1 : rd0;
  assign faded     = fade(prev_data);

  assign wr_plot = (state == ST_DISP) && (w_cmd.kind == KIND_PLOT) && !w_cmd.outside;
  assign wr_fb   = (state == ST_DATA) && (w_cmd.kind == KIND_FEEDBACK);
  assign wr_any  = wr_plot | wr_fb;
  assign wr_en0  = clearing | (wr_any & sel);
  assign wr_en1  = clearing | (wr_any & !sel);
  assign wr_addr = clearing ? clr_cnt : w_here;
  assign wr_data = clearing ? '0 : (wr_fb ? faded : w_cmd.colour);

  assign rd_en   = (state == ST_READ) ||
                   ((state == ST_DISP) && (w_cmd.kind == KIND_READ) && !w_cmd.outside);
  assign rd_addr = (state == ST_READ) ? src : w_here;

  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign busy     = clearing;
  assign res_free = !out_valid || !out_stall;

  ffwd_ram #(.WIDTH(PIXEL_W), .DEPTH(PIX)) u_frame0 (
    .clk, .wr_en(wr_en0), .wr_addr, .wr_data,
    .rd_en, .rd_addr, .rd_data(rd0)
  );

  ffwd_ram #(.WIDTH(PIXEL_W), .DEPTH(PIX)) u_frame1 (
    .clk, .wr_en(wr_en1), .wr_addr, .wr_data,
    .rd_en, .rd_addr, .rd_data(rd1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      sel       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // result register: load a new word or drop the one just taken
      if ((state == ST_RESP) && res_free) out_valid <= 1'b1;
      else if (!out_stall)                out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(PIX-1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (!q_empty) begin
            w_cmd  <= q_cmd;
            w_here <= q_here;
            state  <= ST_DISP;
          end
        end
        ST_DISP: begin
          pix  <= '0;
          outs <= 1'b0;
          if (w_cmd.kind == KIND_SWAP) begin
            sel   <= !sel;
            state <= ST_RESP;
          end else if (w_cmd.outside) begin
            outs  <= 1'b1;
            state <= ST_RESP;
          end else if (w_cmd.kind == KIND_PLOT) begin
            pix   <= w_cmd.colour;
            state <= ST_RESP;
          end else if (w_cmd.kind == KIND_READ) begin
            state <= ST_DATA;
          end else begin
            p_xc  <= 26'(dx) * 26'(scale_cos);
            p_ys  <= 26'(dy) * 26'(scale_sin);
            p_xs  <= 26'(dx) * 26'(scale_sin);
            p_yc  <= 26'(dy) * 26'(scale_cos);
            state <= ST_MAP;
          end
        end
        ST_MAP: begin
          sx    <= sx_next;
          sy    <= sy_next;
          state <= ST_ADDR;
        end
        ST_ADDR: begin
          src   <= AW'(sy) * W_A + AW'(sx);
          state <= ST_READ;
        end
        ST_READ: begin
          state <= ST_DATA;
        end
        ST_DATA: begin
          pix   <= (w_cmd.kind == KIND_FEEDBACK) ? faded : cur_data;
          state <= ST_RESP;
        end
        ST_RESP: begin
          if (res_free) begin
            pixel     <= pix;
            outside   <= outs;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/frame_feedback_warp_decay.sv]
// Sequencer states per word: swap, plot and outside words go DISP, RESP; reads go DISP,
//   DATA, RESP; feedback words go DISP, MAP, ADDR, READ, DATA, RESP. The back-end
//   sequencer handles one word at a time; a 4-entry queue lets the input keep taking
//   words meanwhile. Reset (rst, synchronous): both frame RAMs are swept to zero, one
//   address a cycle in parallel; in_stall is high throughout. Config writes are taken
//   during the sweep.
`default_nettype none

module frame_feedback_warp_decay
  import ffwd_pkg::*;
#(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 240
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // input words
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                kind,
  input  wire logic signed [POS_W-1:0]   pos_x,
  input  wire logic signed [POS_W-1:0]   pos_y,
  input  wire logic [PIXEL_W-1:0]        colour,
  // result words
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [PIXEL_W-1:0]             pixel,
  output logic                           outside,
  // register writes
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic                      cfg_index,
  input  wire logic [SCALE_W-1:0]        cfg_data
);

  localparam int AW      = $clog2(FRAME_WIDTH*FRAME_HEIGHT);
  localparam int CMD_W   = $bits(cmd_t);
  localparam int Q_DEPTH = 4;

  localparam logic REG_SCALE_COS = 1'b0;
  localparam logic REG_SCALE_SIN = 1'b1;
  localparam logic signed [SCALE_W-1:0] COS_RESET = 14'sd4266;
  localparam logic signed [SCALE_W-1:0] SIN_RESET = 14'sd85;

  // Q12 rotate/zoom coefficients
  logic signed [SCALE_W-1:0] scale_cos;
  logic signed [SCALE_W-1:0] scale_sin;

  cmd_t          f_cmd, q_cmd;
  logic [AW-1:0] f_here, q_here;
  logic          push, pop, q_full, q_empty, busy;
  logic [AW+CMD_W-1:0] q_in, q_out;

  // Writes must only be issued while idle; the block does not enforce this, so no back-pressure is given
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_cos <= COS_RESET;
      scale_sin <= SIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCALE_COS: scale_cos <= cfg_data;
        REG_SCALE_SIN: scale_sin <= cfg_data;
        default:       scale_cos <= scale_cos;
      endcase
    end
  end

  // Front end: bounds check and row-major address
  ffwd_front #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_front (
    .in_valid, .in_stall, .kind, .pos_x, .pos_y, .colour,
    .q_full, .busy, .push, .cmd(f_cmd), .here(f_here)
  );

  assign q_in   = {f_here, f_cmd};
  assign q_cmd  = q_out[CMD_W-1:0];
  assign q_here = q_out[AW+CMD_W-1:CMD_W];

  ffwd_fifo #(.WIDTH(AW+CMD_W), .DEPTH(Q_DEPTH)) u_queue (
    .clk, .rst, .push, .wr_data(q_in), .full(q_full),
    .pop, .rd_data(q_out), .empty(q_empty)
  );

  // Back end: warp, frame RAMs, fade, result register
  ffwd_back #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_back (
    .clk, .rst, .scale_cos, .scale_sin,
    .q_empty, .q_cmd, .q_here, .q_pop(pop), .busy,
    .out_valid, .out_stall, .pixel, .outside
  );

endmodule

`default_nettype wire

[sim/testbench.sv]
`default_nettype none

module testbench;
  import ffwd_pkg::*;

  localparam int FRAME_W      = 320;
  localparam int FRAME_H      = 240;
  localparam int FRAME_PIXELS = FRAME_W * FRAME_H;
  localparam int CENTRE_X     = FRAME_W / 2;
  localparam int CENTRE_Y     = FRAME_H / 2;

  // register indexes on the cfg port
  localparam logic REG_SCALE_COS = 1'b0;
  localparam logic REG_SCALE_SIN = 1'b1;

  localparam logic [SCALE_W-1:0] SCALE_MAX   = 14'h1FFF;  // +8191
  localparam logic [SCALE_W-1:0] SCALE_MIN   = 14'h2000;  // -8192
  localparam logic [SCALE_W-1:0] SCALE_UNITY = 14'd4096;

  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 175;
  localparam int MAX_GAP      = 8;
  localparam int TAIL_CYCLES  = 16;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               outside;
  } result_t;

  // Shadow of both frames, the front select and the scale registers; every accepted
  // input word is run through here and the result it should give is queued.
  class warp_scoreboard;
    logic [PIXEL_W-1:0] frames [2*FRAME_PIXELS];
    bit                 front;
    int                 k_cos;
    int                 k_sin;
    result_t            expected_words[$];
    int                 mismatches;

    function new();
      foreach (frames[i]) frames[i] = '0;
      front      = 1'b0;
      k_cos      = 4266;
      k_sin      = 85;
      mismatches = 0;
    endfunction

    function void set_scale(input logic idx, input logic signed [SCALE_W-1:0] v);
      if (idx == REG_SCALE_COS) k_cos = int'(v);
      else k_sin = int'(v);
    endfunction

    // blue steps to zero, green and red stop at one step
    function logic [15:0] dim_rgb565(input logic [15:0] c);
      logic [4:0] r;
      logic [5:0] g;
      logic [4:0] b;
      {r, g, b} = c;
      if (c != 16'd0) begin
        if (b != 5'd0) b = b - 5'd1;
        if (g > 6'd1) g = g - 6'd1;
        if (r > 5'd1) r = r - 5'd1;
      end
      return {r, g, b};
    endfunction

    function int clip_to(input int v, input int hi);
      if (v < 0) return 0;
      return (v > hi) ? hi : v;
    endfunction

    function void note_word(input logic [1:0] k, input logic signed [POS_W-1:0] px,
                            input logic signed [POS_W-1:0] py, input logic [15:0] c);
      int      x;
      int      y;
      int      cur;
      int      prev;
      int      here;
      int      sx;
      int      sy;
      longint  rx;
      longint  ry;
      result_t r;
      x    = int'(px);
      y    = int'(py);
      prev = front ? FRAME_PIXELS : 0;
      cur  = front ? 0 : FRAME_PIXELS;
      r    = '0;
      if (k == KIND_SWAP) begin
        front = ~front;
      end else if (x < 0 || x >= FRAME_W || y < 0 || y >= FRAME_H) begin
        r.outside = 1'b1;
      end else begin
        here = cur + y * FRAME_W + x;
        case (k)
          KIND_FEEDBACK: begin
            rx = longint'(x - CENTRE_X) * k_cos - longint'(y - CENTRE_Y) * k_sin;
            ry = longint'(x - CENTRE_X) * k_sin + longint'(y - CENTRE_Y) * k_cos;
            // arithmetic shift of a signed value floors
            sx = clip_to(int'(rx >>> 12) + CENTRE_X, FRAME_W - 1);
            sy = clip_to(int'(ry >>> 12) + CENTRE_Y, FRAME_H - 1);
            r.pixel = dim_rgb565(frames[prev + sy * FRAME_W + sx]);
            frames[here] = r.pixel;
          end
          KIND_PLOT: begin
            r.pixel = c;
            frames[here] = c;
          end
          default: r.pixel = frames[here];
        endcase
      end
      expected_words.push_back(r);
    endfunction

    function void check_word(input logic [15:0] pix, input logic outs);
      result_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result word: pixel %h outside %b", pix, outs);
      end else begin
        want = expected_words.pop_front();
        if (want.pixel !== pix || want.outside !== outs) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result mismatch: pixel expected %h got %h, outside expected %b got %b",
                     want.pixel, pix, want.outside, outs);
        end
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  // Everything the block sees starts at a known value.
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [1:0]         kind      = KIND_FEEDBACK;
  logic [POS_W-1:0]   pos_x     = '0;
  logic [POS_W-1:0]   pos_y     = '0;
  logic [PIXEL_W-1:0] colour    = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic [PIXEL_W-1:0] pixel;
  logic               outside;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = REG_SCALE_COS;
  logic [SCALE_W-1:0] cfg_data  = '0;

  // stretches where a side never idles
  bit quiet_in  = 1'b0;
  bit quiet_out = 1'b0;

  warp_scoreboard board = new();

  frame_feedback_warp_decay i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .colour    (colour),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel     (pixel),
    .outside   (outside),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Offer one input word after a random gap and hold it until taken. The task is
  // entered on a clock edge; valid stays high into the next word when no gap is drawn.
  task automatic send_word(input logic [1:0] k, input int x, input int y,
                           input logic [15:0] c);
    int unsigned gap;
    gap = quiet_in ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    pos_x    <= x[POS_W-1:0];
    pos_y    <= y[POS_W-1:0];
    colour   <= c;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    board.note_word(k, x[POS_W-1:0], y[POS_W-1:0], c);
  endtask

  // Both scale registers back to back; only called with nothing in flight.
  task automatic load_scales(input logic [SCALE_W-1:0] c, input logic [SCALE_W-1:0] s);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SCALE_COS;
    cfg_data  <= c;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    board.set_scale(REG_SCALE_COS, c);
    cfg_index <= REG_SCALE_SIN;
    cfg_data  <= s;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    board.set_scale(REG_SCALE_SIN, s);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and let every outstanding result word come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Result side: a random hold-off per word, counted from the last word taken, so the
  // stall lands both before and while a result is waiting.
  initial begin : result_sink
    int unsigned hold;
    forever begin
      hold = quiet_out ? 0 : $urandom_range(0, MAX_GAP);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  // Values seen here are the ones before the edge, as the block saw them.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) board.check_word(pixel, outside);
  end

  initial begin : stimulus
    int unsigned roll;
    int unsigned place;
    int          x;
    int          y;
    logic [1:0]  k;
    logic [15:0] c;
    logic [SCALE_W-1:0] sc;
    logic [SCALE_W-1:0] ss;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed words, run with the scale registers at their reset values. The block
    // holds off input while it clears its frames, so the first word waits a long time.
    send_word(KIND_READ, 0, 0, 16'h0000);                     // frames cleared by reset
    send_word(KIND_PLOT, 0, 0, 16'hFFFF);
    send_word(KIND_READ, 0, 0, 16'h0000);
    send_word(KIND_PLOT, FRAME_W - 1, FRAME_H - 1, 16'h0821); // each colour at one step
    send_word(KIND_PLOT, CENTRE_X, CENTRE_Y, 16'hF81F);
    send_word(KIND_PLOT, -1, 0, 16'hFFFF);                    // just left of the frame
    send_word(KIND_PLOT, FRAME_W, FRAME_H - 1, 16'hFFFF);     // just right of it
    send_word(KIND_READ, -1024, -1024, 16'h0000);
    send_word(KIND_FEEDBACK, 1023, 1023, 16'h0000);
    send_word(KIND_FEEDBACK, 0, FRAME_H, 16'h0000);           // just below
    send_word(KIND_SWAP, -1024, 1023, 16'hFFFF);              // position and colour ignored
    send_word(KIND_FEEDBACK, CENTRE_X, CENTRE_Y, 16'h1234);   // centre maps onto itself
    send_word(KIND_FEEDBACK, 0, 0, 16'h0000);                 // source clamps at the low edges
    send_word(KIND_FEEDBACK, FRAME_W - 1, FRAME_H - 1, 16'h0000); // and at the high edges
    send_word(KIND_READ, FRAME_W - 1, FRAME_H - 1, 16'hABCD); // colour ignored on a read
    send_word(KIND_FEEDBACK, 5, 5, 16'h0000);                 // source clamps to 0,0 and fades the white plotted there
    send_word(KIND_PLOT, 1023, -1024, 16'h0000);
    send_word(KIND_SWAP, 0, 0, 16'h0000);
    send_word(KIND_READ, 0, 0, 16'h0000);                     // first frame is current again
    send_word(KIND_SWAP, 0, 0, 16'h0000);
    send_word(KIND_READ, CENTRE_X, CENTRE_Y, 16'h0000);       // fed-back centre pixel
    drain();

    // Random phases, each under its own scale setting. Most words fall in a small
    // window round the centre so that plots, fades and reads keep meeting the same
    // pixels; a few go to the edges, anywhere in the frame, or anywhere at all.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin sc = SCALE_UNITY; ss = '0;        end
        1: begin sc = SCALE_MAX;   ss = SCALE_MIN; end
        2: begin sc = SCALE_MIN;   ss = SCALE_MAX; end
        3: begin sc = '0;          ss = '0;        end  // every source is the centre
        default: begin
          sc = SCALE_W'($urandom_range(0, 16383));
          ss = SCALE_W'($urandom_range(0, 16383));
        end
      endcase
      load_scales(sc, ss);

      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % 40 == 0) begin
          quiet_in  = ($urandom_range(0, 3) == 0);
          quiet_out = ($urandom_range(0, 3) == 0);
        end

        roll = $urandom_range(0, 99);
        if (roll < 30) k = KIND_FEEDBACK;
        else if (roll < 60) k = KIND_PLOT;
        else if (roll < 85) k = KIND_READ;
        else if (roll < 92) k = KIND_SWAP;
        else k = 2'($urandom_range(0, 3));

        place = $urandom_range(0, 9);
        if (place < 6) begin
          x = CENTRE_X - 8 + int'($urandom_range(0, 15));
          y = CENTRE_Y - 8 + int'($urandom_range(0, 15));
        end else if (place == 6) begin
          x = $urandom_range(0, 1) ? int'($urandom_range(0, 2))
                                   : FRAME_W - 1 - int'($urandom_range(0, 2));
          y = $urandom_range(0, 1) ? int'($urandom_range(0, 2))
                                   : FRAME_H - 1 - int'($urandom_range(0, 2));
        end else if (place == 7) begin
          x = int'($urandom_range(0, FRAME_W - 1));
          y = int'($urandom_range(0, FRAME_H - 1));
        end else begin
          x = int'($urandom_range(0, 2047)) - 1024;
          y = int'($urandom_range(0, 2047)) - 1024;
        end

        // a quarter of the colours sit at the fade corners of each field
        c = 16'($urandom);
        if ($urandom_range(0, 3) == 0) begin
          c[15:11] = 5'($urandom_range(0, 2));
          c[10:5]  = 6'($urandom_range(0, 2));
          c[4:0]   = 5'($urandom_range(0, 2));
        end

        send_word(k, x, y, c);
      end
      drain();
    end

    quiet_out = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // time for the clearing sweep plus the slowest run, with far more to spare
  initial begin : watchdog
    #(8 * 1_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/ffwd_pkg.sv
rtl/ffwd_ram.sv
rtl/ffwd_fifo.sv
rtl/ffwd_front.sv
rtl/ffwd_back.sv
rtl/frame_feedback_warp_decay.sv
sim/testbench.sv
